// ----- design/masked_byte_pattern_search_macros.svh -----
// Assertion macros shared by the search block.
`ifndef MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MBPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mbps_pkg.sv -----
`timescale 1ns / 1ps

package mbps_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int ADDR_BITS_DEF   = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PLEN_W     = 5;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_MASK_LOW     = 3'd2,
        REG_MASK_HIGH    = 3'd3,
        REG_PATTERN_LEN  = 3'd4,
        REG_CASE_FOLD    = 3'd5
    } cfg_reg_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic advance;    // an item is accepted this cycle
        logic restart;    // drop all partial matches before this byte
        logic case_fold;  // fold ASCII upper case to lower case
    } cell_ctrl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && (b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z))
        begin
            r = b - ASCII_UPPER_A + ASCII_LOWER_A;
        end
        return r;
    endfunction

endpackage

// ----- design/mbps_cell.sv -----
`timescale 1ns / 1ps

// One pattern position: compare the byte, hold one partial-match bit.
module mbps_cell
    import mbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] data_folded,
    input  logic [7:0] pattern_byte,
    input  logic [7:0] mask_byte,
    input  logic       enable,
    input  logic       shift_in,
    output logic       match_next,
    output logic       match_reg
);

    logic [7:0] pat_folded;
    logic       eq;

    assign pat_folded = fold_byte(pattern_byte, ctrl.case_fold);
    assign eq         = ((data_folded & mask_byte) == (pat_folded & mask_byte));
    assign match_next = shift_in & eq & enable;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            match_reg <= match_next;
        end
    end

endmodule

// ----- design/masked_byte_pattern_search.sv -----
`timescale 1ns / 1ps

// Masked byte pattern search: scans a byte stream for a pattern of up to
// MAX_PATTERN bytes, each position with its own compare mask, optional ASCII
// case fold. All partial matches are tracked, so overlapping hits all show.
// Input channel: item_valid / item_stall with data_byte, byte_address and
// restart; one word is taken when item_valid is high and item_stall is low.
// Output channel: result_valid / result_stall with found and match_address
// (start of the match, zero when found is low). One result word per input.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; ready is
// always high. Write only while the block is idle.
// Result: each accepted word's result is registered in the output slot, or in the skid slot when that is held.
// Throughput: one word per cycle while item_stall is low; every cell updates its
// match bit in the cycle of acceptance, so nothing in the cell row limits the rate.
// Stall: the output register has a one-word skid behind it, so one more word
// is taken while result_stall is high; input stalls only when both are full.
// Reset: partial matches clear, masks go to all ones, pattern, length and
// case fold to zero, both output slots empty.
`include "masked_byte_pattern_search_macros.svh"

module masked_byte_pattern_search
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input words
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [7:0]            data_byte,
    input  logic [ADDR_BITS-1:0]  byte_address,
    input  logic                  restart,
    // result words
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  found,
    output logic [ADDR_BITS-1:0]  match_address,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // Configuration registers
    logic [CFG_DATA_W-1:0] pattern_low_reg, pattern_high_reg;
    logic [CFG_DATA_W-1:0] mask_low_reg, mask_high_reg;
    logic [PLEN_W-1:0]     pattern_length_reg;
    logic                  case_fold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            mask_low_reg       <= '1;
            mask_high_reg      <= '1;
            pattern_length_reg <= '0;
            case_fold_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                REG_MASK_LOW:     mask_low_reg       <= cfg_data;
                REG_MASK_HIGH:    mask_high_reg      <= cfg_data;
                REG_PATTERN_LEN:  pattern_length_reg <= cfg_data[PLEN_W-1:0];
                REG_CASE_FOLD:    case_fold_reg      <= cfg_data[0];
                default:          ; // unmapped index: drop the write
            endcase
        end
    end

    // Saturate the length at the number of cells
    logic [LEN_W-1:0] eff_len;
    assign eff_len = (pattern_length_reg > PLEN_W'(MAX_PATTERN))
                   ? LEN_W'(MAX_PATTERN) : LEN_W'(pattern_length_reg);

    // Handshake and output slots
    logic                 accept;
    logic                 out_fire;
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic                 found_reg, skid_found_reg;
    logic [ADDR_BITS-1:0] addr_reg, skid_addr_reg;

    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !item_stall;
    assign out_fire   = out_valid_reg && !result_stall;

    cell_ctrl_t ctrl;
    assign ctrl.advance   = accept;
    assign ctrl.restart   = restart;
    assign ctrl.case_fold = case_fold_reg;

    logic [7:0] data_folded;
    assign data_folded = fold_byte(data_byte, case_fold_reg);

    logic [2*CFG_DATA_W-1:0] pattern_all, mask_all;
    assign pattern_all = {pattern_high_reg, pattern_low_reg};
    assign mask_all    = {mask_high_reg, mask_low_reg};

    // Row of cells: cell i holds "bytes 0..i matched ending at the last byte"
    logic [MAX_PATTERN-1:0] state_reg;
    logic [MAX_PATTERN-1:0] state_next;
    logic [MAX_PATTERN-1:0] shift_in;
    logic [MAX_PATTERN-1:0] last_sel;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign shift_in[i] = 1'b1;
        end
        else
        begin : g_body
            assign shift_in[i] = state_reg[i-1] & ~ctrl.restart;
        end

        assign last_sel[i] = (LEN_W'(i + 1) == eff_len);

        mbps_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .data_folded  (data_folded),
            .pattern_byte (pattern_all[8*i +: 8]),
            .mask_byte    (mask_all[8*i +: 8]),
            .enable       (LEN_W'(i) < eff_len),
            .shift_in     (shift_in[i]),
            .match_next   (state_next[i]),
            .match_reg    (state_reg[i])
        );
    end

    // Full match when the cell at the last pattern position fires
    logic                 found_c;
    logic [ADDR_BITS-1:0] start_c;
    assign found_c = |(state_next & last_sel);
    assign start_c = found_c
                   ? (byte_address - ADDR_BITS'(eff_len) + ADDR_BITS'(1))
                   : '0;

    // Output register with one skid slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (accept)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next  = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (!out_valid_reg || out_fire))
        begin
            found_reg <= found_c;
            addr_reg  <= start_c;
        end
        else if (accept)
        begin
            skid_found_reg <= found_c;
            skid_addr_reg  <= start_c;
        end
        else if (out_fire && skid_valid_reg)
        begin
            // advance the skid word into the output slot
            found_reg <= skid_found_reg;
            addr_reg  <= skid_addr_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;

    `MBPS_ASSERT_NOW(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid word without output word")
    `MBPS_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_reg, "accepted word produced no result")
    `MBPS_ASSERT_NOW(a_addr_zero_on_miss, result_valid && !found, match_address == '0, "address set without a match")
    `MBPS_ASSERT_NEXT(a_zero_len_idle, accept && (eff_len == '0), state_reg == '0, "zero length left partial matches")

endmodule
